[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the page frame allocator, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// rfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package rfa_pkg;
	localparam int PAGE_COUNT_DEF = 262144;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W = 48;
	localparam int CNT_OUT_W = 19;
	localparam int ALLOC_OUT_W = 30;
	localparam int REF_W = 16;
	localparam logic [REF_W-1:0] REF_MAX = '1;

	typedef enum logic [1:0] {
		KIND_UNTRACKED = 2'd0,
		KIND_FREE      = 2'd1,
		KIND_RESERVED  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REQ_ALLOC    = 3'd0,
		REQ_FREE     = 3'd1,
		REQ_RETAIN   = 3'd2,
		REQ_MARK     = 3'd3,
		REQ_RESERVE  = 3'd4
	} req_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SETUP, ST_ALLOC_RD, ST_ALLOC_CHK,
		ST_PG_RD, ST_PG_CHK, ST_RNG_RD, ST_RNG_CHK, ST_DONE
	} state_t;

	typedef struct packed {
		kind_t            kind;
		logic [REF_W-1:0] refcnt;
	} page_ent_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0]   tracked_count;
		logic [CNT_OUT_W-1:0]   reserved_count;
		logic [CNT_OUT_W-1:0]   free_count;
		logic [ALLOC_OUT_W-1:0] alloc_address;
		logic                   status;
	} res_t;
endpackage

[rtl/rfa_ram.sv]
// ----------------------------------------------------------------------------
// rfa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rfa_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/rfa_engine.sv]
// ----------------------------------------------------------------------------
// rfa_engine
// request sequencer: clears the page store, then reads, modifies and writes
// page entries one at a time for allocate, free, retain and range requests
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rfa_engine #(
	parameter int PAGE_COUNT = rfa_pkg::PAGE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        in_req,
	input  logic [rfa_pkg::ADDR_W-1:0]        in_address,
	input  logic [rfa_pkg::ADDR_W-1:0]        in_size,
	output logic                              res_valid,
	input  logic                              res_ready,
	output rfa_pkg::res_t                     res,
	output logic                              mem_we,
	output logic [$clog2(PAGE_COUNT)-1:0]     mem_addr,
	output rfa_pkg::page_ent_t                mem_wdata,
	input  rfa_pkg::page_ent_t                mem_rdata
);
	localparam int AW = $clog2(PAGE_COUNT);
	localparam int PW = $clog2(PAGE_COUNT + 1);
	localparam int SW = rfa_pkg::ADDR_W + 2;
	localparam int FW = SW - rfa_pkg::PAGE_SHIFT;
	localparam int PGW = rfa_pkg::ADDR_W - rfa_pkg::PAGE_SHIFT;
	localparam logic [SW-1:0] PAGE_MASK = SW'((1 << rfa_pkg::PAGE_SHIFT) - 1);

	rfa_pkg::state_t state_q, state_d;
	logic [2:0] req_q, req_d;
	logic [rfa_pkg::ADDR_W-1:0] addr_q, addr_d, size_q, size_d;
	logic [PW-1:0] p_q, p_d, last_q, last_d, floor_q, floor_d;
	logic [PW-1:0] free_q, free_d, rsv_q, rsv_d, trk_q, trk_d;
	logic status_q, status_d;
	logic [rfa_pkg::ALLOC_OUT_W-1:0] alloc_q, alloc_d;

	logic [SW-1:0] base_x, sum_x, first_x, last_x;
	logic [FW-1:0] first_pg, last_pg;
	logic [PGW-1:0] in_pg;
	logic [PW-1:0] p_inc;
	logic is_mark;
	logic st_idle, st_quiet;

	assign mem_addr = p_q[AW-1:0];
	assign p_inc = p_q + PW'(1);
	assign in_pg = in_address[rfa_pkg::ADDR_W-1:rfa_pkg::PAGE_SHIFT];
	assign is_mark = (req_q == rfa_pkg::REQ_MARK);
	assign base_x = {2'b00, addr_q};
	assign sum_x = base_x + {2'b00, size_q};
	assign first_x = is_mark ? (base_x + PAGE_MASK) : base_x;
	assign last_x = is_mark ? sum_x : (sum_x + PAGE_MASK);
	assign first_pg = first_x[SW-1:rfa_pkg::PAGE_SHIFT];
	assign last_pg = last_x[SW-1:rfa_pkg::PAGE_SHIFT];
	assign st_idle = (state_q == rfa_pkg::ST_IDLE);
	assign st_quiet = st_idle || (state_q == rfa_pkg::ST_DONE);

	always_comb begin
		state_d = state_q;
		req_d = req_q;
		addr_d = addr_q;
		size_d = size_q;
		p_d = p_q;
		last_d = last_q;
		floor_d = floor_q;
		free_d = free_q;
		rsv_d = rsv_q;
		trk_d = trk_q;
		status_d = status_q;
		alloc_d = alloc_q;
		in_ready = 1'b0;
		res_valid = 1'b0;
		mem_we = 1'b0;
		mem_wdata = mem_rdata;
		unique case (state_q)
			rfa_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wdata = '{kind: rfa_pkg::KIND_UNTRACKED, refcnt: '0};
				if (p_q == PW'(PAGE_COUNT - 1)) begin
					p_d = '0;
					state_d = rfa_pkg::ST_IDLE;
				end else begin
					p_d = p_inc;
				end
			end
			rfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					req_d = in_req;
					addr_d = in_address;
					size_d = in_size;
					alloc_d = '0;
					status_d = 1'b1;
					unique case (in_req)
						rfa_pkg::REQ_ALLOC: begin
							p_d = floor_q;
							state_d = rfa_pkg::ST_ALLOC_RD;
						end
						rfa_pkg::REQ_FREE, rfa_pkg::REQ_RETAIN: begin
							if (in_address[rfa_pkg::PAGE_SHIFT-1:0] != '0 ||
									{1'b0, in_pg} >= (PGW+1)'(PAGE_COUNT)) begin
								state_d = rfa_pkg::ST_DONE;
							end else begin
								p_d = PW'(in_pg);
								state_d = rfa_pkg::ST_PG_RD;
							end
						end
						rfa_pkg::REQ_MARK, rfa_pkg::REQ_RESERVE: begin
							state_d = rfa_pkg::ST_SETUP;
						end
						default: begin
							state_d = rfa_pkg::ST_DONE;
						end
					endcase
				end
			end
			rfa_pkg::ST_SETUP: begin
				status_d = 1'b0;
				p_d = (first_pg >= FW'(PAGE_COUNT)) ? PW'(PAGE_COUNT) : PW'(first_pg);
				last_d = (last_pg >= FW'(PAGE_COUNT)) ? PW'(PAGE_COUNT) : PW'(last_pg);
				state_d = rfa_pkg::ST_RNG_RD;
			end
			rfa_pkg::ST_ALLOC_RD: begin
				if (p_q >= PW'(PAGE_COUNT)) begin
					floor_d = PW'(PAGE_COUNT);
					state_d = rfa_pkg::ST_DONE;
				end else begin
					state_d = rfa_pkg::ST_ALLOC_CHK;
				end
			end
			rfa_pkg::ST_ALLOC_CHK: begin
				if (mem_rdata.kind == rfa_pkg::KIND_FREE) begin
					mem_we = 1'b1;
					mem_wdata = '{kind: rfa_pkg::KIND_RESERVED, refcnt: rfa_pkg::REF_W'(1)};
					if (free_q != '0) begin
						free_d = free_q - PW'(1);
					end
					rsv_d = rsv_q + PW'(1);
					floor_d = p_inc;
					alloc_d = rfa_pkg::ALLOC_OUT_W'({p_q, rfa_pkg::PAGE_SHIFT'(0)});
					status_d = 1'b0;
					state_d = rfa_pkg::ST_DONE;
				end else begin
					p_d = p_inc;
					state_d = rfa_pkg::ST_ALLOC_RD;
				end
			end
			rfa_pkg::ST_PG_RD: begin
				state_d = rfa_pkg::ST_PG_CHK;
			end
			rfa_pkg::ST_PG_CHK: begin
				state_d = rfa_pkg::ST_DONE;
				if (mem_rdata.kind == rfa_pkg::KIND_RESERVED) begin
					if (req_q == rfa_pkg::REQ_FREE) begin
						status_d = 1'b0;
						mem_we = 1'b1;
						if (mem_rdata.refcnt > rfa_pkg::REF_W'(1)) begin
							mem_wdata.refcnt = mem_rdata.refcnt - rfa_pkg::REF_W'(1);
						end else begin
							mem_wdata = '{kind: rfa_pkg::KIND_FREE, refcnt: '0};
							free_d = free_q + PW'(1);
							if (rsv_q != '0) begin
								rsv_d = rsv_q - PW'(1);
							end
							if (p_q < floor_q) begin
								floor_d = p_q;
							end
						end
					end else if (mem_rdata.refcnt != '0 && mem_rdata.refcnt != rfa_pkg::REF_MAX) begin
						status_d = 1'b0;
						mem_we = 1'b1;
						mem_wdata.refcnt = mem_rdata.refcnt + rfa_pkg::REF_W'(1);
					end
				end
			end
			rfa_pkg::ST_RNG_RD: begin
				if (p_q >= last_q) begin
					state_d = rfa_pkg::ST_DONE;
				end else begin
					state_d = rfa_pkg::ST_RNG_CHK;
				end
			end
			rfa_pkg::ST_RNG_CHK: begin
				p_d = p_inc;
				state_d = rfa_pkg::ST_RNG_RD;
				if (is_mark) begin
					if (mem_rdata.kind == rfa_pkg::KIND_UNTRACKED) begin
						mem_we = 1'b1;
						mem_wdata.kind = rfa_pkg::KIND_FREE;
						trk_d = trk_q + PW'(1);
						free_d = free_q + PW'(1);
						if (p_q < floor_q) begin
							floor_d = p_q;
						end
					end
				end else begin
					mem_we = 1'b1;
					mem_wdata.kind = rfa_pkg::KIND_RESERVED;
					if (mem_rdata.kind == rfa_pkg::KIND_FREE && free_q != '0) begin
						free_d = free_q - PW'(1);
						rsv_d = rsv_q + PW'(1);
					end
				end
			end
			rfa_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = rfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rfa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::ST_CLEAR;
			p_q <= '0;
			floor_q <= '0;
			free_q <= '0;
			rsv_q <= '0;
			trk_q <= '0;
		end else begin
			state_q <= state_d;
			p_q <= p_d;
			floor_q <= floor_d;
			free_q <= free_d;
			rsv_q <= rsv_d;
			trk_q <= trk_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		addr_q <= addr_d;
		size_q <= size_d;
		last_q <= last_d;
		status_q <= status_d;
		alloc_q <= alloc_d;
	end

	assign res.status = status_q;
	assign res.alloc_address = alloc_q;
	assign res.free_count = rfa_pkg::CNT_OUT_W'(free_q);
	assign res.reserved_count = rfa_pkg::CNT_OUT_W'(rsv_q);
	assign res.tracked_count = rfa_pkg::CNT_OUT_W'(trk_q);

	`ASSERT_SAME(a_no_write_idle, mem_we, !st_quiet, "page write outside a modify step")
	`ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, !st_idle, "accepted beat left engine idle")
	`ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid, "pending result dropped")
endmodule

[rtl/rfa_out_buf.sv]
// ----------------------------------------------------------------------------
// rfa_out_buf
// one-entry output register between the engine and the result channel
// ----------------------------------------------------------------------------
module rfa_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rfa_pkg::res_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rfa_pkg::res_t out_data
);
	logic valid_q;
	rfa_pkg::res_t data_q;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end
endmodule

[rtl/refcounted_page_frame_allocator_unit.sv]
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_unit
// physical page frame allocator with per-page reference counts
// ----------------------------------------------------------------------------
// requests arrive as beats on the s_ channel, one result beat per request
// leaves on the m_ channel, in order
// page state (kind and 16-bit count) lives in one ram of PAGE_COUNT entries,
// each request reads, modifies and writes one entry at a time
// free and retain read and then update the one addressed page, rejected
// requests go straight to the result, allocate scans pages upward from
// the lowest page that may be free until it takes a free page or reaches
// the top, range requests visit each page in the rounded range
// one request is handled at a time; the next is taken once the result of
// the previous one sits in the output register
// after reset every ram entry is swept to untracked with s_tready
// low; counts start at zero
// a stalled m_ side holds the result and blocks a further request only
// once the output register and the engine are both full
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_unit #(
	parameter int PAGE_COUNT = rfa_pkg::PAGE_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // req_type[2:0], address[50:3], range_size[98:51]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata   // status, alloc_address, free, reserved, tracked counts
);
	logic res_valid, res_ready, mem_we;
	rfa_pkg::res_t res, out_res;
	logic [$clog2(PAGE_COUNT)-1:0] mem_addr;
	rfa_pkg::page_ent_t mem_wdata, mem_rdata;

	rfa_engine #(.PAGE_COUNT(PAGE_COUNT)) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(s_tdata[2:0]),
		.in_address(s_tdata[50:3]),
		.in_size(s_tdata[98:51]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	rfa_ram #(.WIDTH($bits(rfa_pkg::page_ent_t)), .DEPTH(PAGE_COUNT)) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_addr),
		.wdata(mem_wdata),
		.raddr(mem_addr),
		.rdata(mem_rdata)
	);

	rfa_out_buf u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(res_valid),
		.in_ready(res_ready),
		.in_data(res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(out_res)
	);

	assign m_tdata = out_res;
endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the page frame allocator against a cycle-free model of its page store
// ----------------------------------------------------------------------------
// requests are driven from a queue with random gaps; every accepted request is
// run through a local model of page kinds, reference counts and running page
// counts, and each result beat is compared field by field with the oldest
// prediction; the run covers range rounding, repeated retains, exhaustion
// of free pages, malformed requests and long back-pressure on the result side
// ----------------------------------------------------------------------------
module testbench;
	localparam int NPAGES = rfa_pkg::PAGE_COUNT_DEF;
	localparam longint unsigned PG = 64'd4096;
	localparam int IDLE_LIMIT = 2000000;

	typedef struct {
		logic [2:0]  req;
		logic [47:0] addr;
		logic [47:0] size;
		bit          drain;
		bit          raw;
	} page_req_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;  // req_type[2:0], address[50:3], range_size[98:51]
	logic         m_tvalid;
	logic         m_tready;
	logic [87:0]  m_tdata;  // status, alloc_address, free, reserved, tracked counts

	page_req_t      pending_reqs[$];
	rfa_pkg::res_t  expected_results[$];
	rfa_pkg::kind_t kind_of[NPAGES];
	logic [15:0]    refs_of[NPAGES];
	int unsigned n_free, n_reserved, n_tracked, scan_floor;
	int          mismatches, gap_left, idle_cycles, results_seen, hold_left;
	bit          s_fire, burst_mode, failed, long_hold_done;

	refcounted_page_frame_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned clamp_page(longint unsigned v);
		return (v > NPAGES) ? NPAGES : v;
	endfunction

	function automatic rfa_pkg::res_t apply_request(logic [2:0] req, logic [47:0] addr,
			logic [47:0] size);
		rfa_pkg::res_t r;
		longint unsigned a, s, first, last, p;
		bit ok, found;
		a = addr;
		s = size;
		ok = 1'b0;
		r = '0;
		case (req)
			rfa_pkg::REQ_ALLOC: begin
				found = 1'b0;
				for (p = scan_floor; p < NPAGES && !found; p++) begin
					if (kind_of[p] == rfa_pkg::KIND_FREE) begin
						found = 1'b1;
						kind_of[p] = rfa_pkg::KIND_RESERVED;
						refs_of[p] = 16'd1;
						if (n_free > 0) n_free--;
						n_reserved++;
						scan_floor = 32'(p + 1);
						r.alloc_address = rfa_pkg::ALLOC_OUT_W'(p << rfa_pkg::PAGE_SHIFT);
					end
				end
				if (!found) scan_floor = NPAGES;
				ok = found;
			end
			rfa_pkg::REQ_FREE, rfa_pkg::REQ_RETAIN: begin
				p = a >> rfa_pkg::PAGE_SHIFT;
				if ((a % PG) == 0 && p < NPAGES && kind_of[p] == rfa_pkg::KIND_RESERVED) begin
					if (req == rfa_pkg::REQ_FREE) begin
						ok = 1'b1;
						if (refs_of[p] > 1) begin
							refs_of[p]--;
						end else begin
							refs_of[p] = '0;
							kind_of[p] = rfa_pkg::KIND_FREE;
							n_free++;
							if (n_reserved > 0) n_reserved--;
							if (p < scan_floor) scan_floor = 32'(p);
						end
					end else if (refs_of[p] != 0 && refs_of[p] != rfa_pkg::REF_MAX) begin
						ok = 1'b1;
						refs_of[p]++;
					end
				end
			end
			rfa_pkg::REQ_MARK: begin
				ok = 1'b1;
				first = (a + PG - 1) >> rfa_pkg::PAGE_SHIFT;
				last = clamp_page((a + s) >> rfa_pkg::PAGE_SHIFT);
				for (p = first; p < last; p++) begin
					if (kind_of[p] == rfa_pkg::KIND_UNTRACKED) begin
						kind_of[p] = rfa_pkg::KIND_FREE;
						n_tracked++;
						n_free++;
						if (p < scan_floor) scan_floor = 32'(p);
					end
				end
			end
			rfa_pkg::REQ_RESERVE: begin
				ok = 1'b1;
				first = a >> rfa_pkg::PAGE_SHIFT;
				last = clamp_page((a + s + PG - 1) >> rfa_pkg::PAGE_SHIFT);
				for (p = first; p < last; p++) begin
					if (kind_of[p] == rfa_pkg::KIND_FREE && n_free > 0) begin
						n_free--;
						n_reserved++;
					end
					kind_of[p] = rfa_pkg::KIND_RESERVED;
				end
			end
			default: ok = 1'b0;
		endcase
		r.status = !ok;
		r.free_count = rfa_pkg::CNT_OUT_W'(n_free);
		r.reserved_count = rfa_pkg::CNT_OUT_W'(n_reserved);
		r.tracked_count = rfa_pkg::CNT_OUT_W'(n_tracked);
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		if (burst_mode) return 0;
		k = $urandom_range(99);
		if (k < 60) return 0;
		if (k < 90) return $urandom_range(3, 1);
		if (k < 98) return $urandom_range(15, 4);
		return $urandom_range(80, 30);
	endfunction

	task automatic add_req(logic [2:0] req, longint unsigned addr, longint unsigned size,
			bit drain = 0, bit raw = 0);
		page_req_t it;
		it.req = req;
		it.addr = addr[47:0];
		it.size = size[47:0];
		it.drain = drain;
		it.raw = raw;
		pending_reqs.push_back(it);
	endtask

	function automatic longint unsigned low_page_addr();
		return longint'($urandom_range(63)) * PG;
	endfunction

	// driver
	always @(negedge clk) begin
		page_req_t it;
		if (!arst_n) begin
			s_tvalid = 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (s_fire && ($urandom_range(199) == 0)) burst_mode = !burst_mode;
			if (gap_left > 0) begin
				s_tvalid = 1'b0;
				gap_left--;
			end else if (pending_reqs.size() > 0 &&
					(!pending_reqs[0].drain || expected_results.size() == 0)) begin
				it = pending_reqs.pop_front();
				// keep failing allocations rare, a failed scan runs to the top
				if (!it.raw && it.req == rfa_pkg::REQ_ALLOC && n_free == 0) begin
					it.req = rfa_pkg::REQ_MARK;
					it.addr = 48'(low_page_addr() + longint'($urandom_range(4095)));
					it.size = 48'($urandom_range(8 * 4096));
				end
				s_tdata = {5'd0, it.size, it.addr, it.req};
				s_tvalid = 1'b1;
				gap_left = pick_gap();
			end else begin
				s_tvalid = 1'b0;
			end
		end
	end

	// result side ready, with one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else if (!long_hold_done && results_seen >= 300) begin
			long_hold_done = 1'b1;
			hold_left = 600;
			m_tready = 1'b0;
		end else if (burst_mode) begin
			m_tready = 1'b1;
		end else begin
			m_tready = ($urandom_range(99) < 70) || ($urandom_range(99) < 20);
			if ($urandom_range(299) == 0) hold_left = $urandom_range(60, 20);
		end
	end

	// monitor, prediction and watchdog
	always @(posedge clk) begin
		rfa_pkg::res_t got, want;
		if (arst_n) begin
			s_fire = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got = rfa_pkg::res_t'(m_tdata);
				results_seen++;
				if (expected_results.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.alloc_address !== want.alloc_address ||
							got.free_count !== want.free_count ||
							got.reserved_count !== want.reserved_count ||
							got.tracked_count !== want.tracked_count) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected st=%0d addr=%h f=%0d r=%0d t=%0d,",
								want.status, want.alloc_address, want.free_count,
								want.reserved_count, want.tracked_count,
								" got st=%0d addr=%h f=%0d r=%0d t=%0d", got.status,
								got.alloc_address, got.free_count, got.reserved_count,
								got.tracked_count);
					end
				end
			end
			if (s_fire)
				expected_results.push_back(apply_request(s_tdata[2:0], s_tdata[50:3],
					s_tdata[98:51]));
			if (s_fire || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int k;
		int sel;
		longint unsigned top;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		s_fire = 1'b0;
		burst_mode = 1'b0;
		failed = 1'b0;
		long_hold_done = 1'b0;
		mismatches = 0;
		gap_left = 0;
		idle_cycles = 0;
		results_seen = 0;
		hold_left = 0;
		n_free = 0;
		n_reserved = 0;
		n_tracked = 0;
		scan_floor = 0;
		foreach (kind_of[i]) begin
			kind_of[i] = rfa_pkg::KIND_UNTRACKED;
			refs_of[i] = '0;
		end
		top = longint'(NPAGES) * PG;

		// directed
		add_req(rfa_pkg::REQ_ALLOC, 0, 0, 0, 1);
		add_req(rfa_pkg::REQ_MARK, 4097, 3 * 4096);
		add_req(rfa_pkg::REQ_MARK, 0, 8 * 4096);
		add_req(rfa_pkg::REQ_MARK, top - 3 * PG + 5, 48'hFFFF_FFFF_FFFF);
		add_req(rfa_pkg::REQ_MARK, 20 * PG, 0);
		add_req(rfa_pkg::REQ_ALLOC, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		add_req(rfa_pkg::REQ_RETAIN, 0, 0);
		add_req(rfa_pkg::REQ_FREE, 0, 0);
		add_req(rfa_pkg::REQ_FREE, 0, 0);
		add_req(rfa_pkg::REQ_FREE, 0, 0);
		add_req(rfa_pkg::REQ_FREE, 4096 + 8, 0);
		add_req(rfa_pkg::REQ_RETAIN, 2049, 0);
		add_req(rfa_pkg::REQ_FREE, top, 0);
		add_req(rfa_pkg::REQ_RETAIN, 48'hFFFF_FFFF_F000, 0);
		add_req(rfa_pkg::REQ_RETAIN, 3 * PG, 0);
		add_req(rfa_pkg::REQ_RESERVE, 5 * PG + 100, 10);
		add_req(rfa_pkg::REQ_RESERVE, top - 2 * PG, 48'hFFFF_FFFF_FFFF);
		add_req(rfa_pkg::REQ_RESERVE, 9 * PG, 0);
		add_req(rfa_pkg::REQ_RETAIN, 5 * PG, 0);
		add_req(rfa_pkg::REQ_FREE, 5 * PG, 0);
		add_req(3'd5, 0, 0);
		add_req(3'd6, PG, PG);
		add_req(3'd7, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		for (k = 0; k < 12; k++) add_req(rfa_pkg::REQ_ALLOC, 0, 0, 0, 1);

		// repeated retains on page two
		add_req(rfa_pkg::REQ_FREE, 2 * PG, 0, 1);
		add_req(rfa_pkg::REQ_ALLOC, 0, 0);
		for (k = 0; k < 20; k++) add_req(rfa_pkg::REQ_RETAIN, 2 * PG, 0);

		// random
		for (k = 0; k < 1800; k++) begin
			sel = $urandom_range(99);
			if (sel < 22) begin
				add_req(rfa_pkg::REQ_ALLOC, {$urandom, $urandom}, {$urandom, $urandom});
			end else if (sel < 44) begin
				add_req(rfa_pkg::REQ_FREE, low_page_addr(), {$urandom, $urandom});
			end else if (sel < 60) begin
				add_req(rfa_pkg::REQ_RETAIN, low_page_addr(), {$urandom, $urandom});
			end else if (sel < 72) begin
				add_req(rfa_pkg::REQ_MARK, low_page_addr() + $urandom_range(4095) *
					$urandom_range(1), $urandom_range(10 * 4096));
			end else if (sel < 82) begin
				add_req(rfa_pkg::REQ_RESERVE, low_page_addr() + $urandom_range(4095) *
					$urandom_range(1), $urandom_range(6 * 4096));
			end else if (sel < 88) begin
				add_req(3'($urandom_range(2, 1)), {$urandom, $urandom}, 0);
			end else if (sel < 92) begin
				add_req(3'($urandom_range(4, 3)),
					{$urandom, $urandom} | 64'h0000_0000_4000_0000, {$urandom, $urandom});
			end else if (sel < 94) begin
				add_req(3'($urandom_range(7, 5)), {$urandom, $urandom},
					{$urandom, $urandom});
			end else if (sel < 96) begin
				add_req(rfa_pkg::REQ_RESERVE, top - $urandom_range(8) * PG,
					{$urandom, $urandom});
			end else begin
				add_req(rfa_pkg::REQ_FREE, low_page_addr(), 0, 1);
			end
		end

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		wait (pending_reqs.size() == 0);
		wait (expected_results.size() == 0 && !s_tvalid);
		repeat (100) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial arst_n = 1'b0;
endmodule

[filelist.f]
+incdir+rtl
rtl/rfa_pkg.sv
rtl/rfa_ram.sv
rtl/rfa_engine.sv
rtl/rfa_out_buf.sv
rtl/refcounted_page_frame_allocator_unit.sv
dv/testbench.sv
